// File: sv/bitmap_first_free_allocator_defines.svh
// ----------------------------------------------------------------------------
// Bitmap first-free allocator assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BFFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");
// Next-cycle implication.
`define BFFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");
`else
`define BFFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BFFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/bffa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap first-free allocator package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int NUM_W     = 14;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int WORD_W    = 32;

    // Command codes carried in tuser of the input stream.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_NALLOC = 2'd3;

    // Register word index (paddr[2]).
    localparam logic REG_LIMIT = 1'b0;
    localparam logic [NUM_W-1:0] LIMIT_RESET = 14'd8192;

    typedef struct packed {
        logic clear;
        logic accept;
        logic free_chk;
        logic scan;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_free;
        logic in_bad;
        logic lim_zero;
        logic scan_done;
        logic out_free;
    } t_ctl_sts;

endpackage

// File: sv/bffa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap allocator controller
// Sequences the clearing pass, free checks, allocation scans and result load.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  bffa_pkg::t_ctl_sts i_sts,
    output bffa_pkg::t_ctl_cmd o_cmd,
    output logic               o_s_tready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_accept;

    assign w_accept = i_s_tvalid & r_ready;

    always_comb begin
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.accept   = w_accept;
        o_cmd.free_chk = (r_state == S_FREE);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.load     = (r_state == S_DONE) & i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.in_free) begin
                        n_state = i_sts.in_bad ? S_DONE : S_FREE;
                    end else begin
                        n_state = i_sts.lim_zero ? S_DONE : S_SCAN;
                    end
                end
            end
            S_FREE: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_s_tready = r_ready;

endmodule

// File: sv/bffa_dp.sv
// ----------------------------------------------------------------------------
// Bitmap allocator datapath
// Bitmap RAM, word scanner, used counter, limit register and result register.
// ----------------------------------------------------------------------------
module bffa_dp #(
    parameter int NUM_ENTRIES = 8192
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bffa_pkg::t_ctl_cmd               i_cmd,
    output bffa_pkg::t_ctl_sts               o_sts,
    input  logic [bffa_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bffa_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [1:0]                       o_m_tuser,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [bffa_pkg::APB_AW-1:0]      i_paddr,
    input  logic [bffa_pkg::APB_DW-1:0]      i_pwdata,
    output logic [bffa_pkg::APB_DW-1:0]      o_prdata
);

    localparam int NW    = bffa_pkg::NUM_W;
    localparam int WW    = bffa_pkg::WORD_W;
    localparam int WORDS = (NUM_ENTRIES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = AW + 1;
    localparam int BW    = (AW + 5 > NW) ? AW + 6 : NW + 1;
    localparam logic [16:0] NUM_X = 17'(NUM_ENTRIES);

    logic [NW-1:0] r_limit;
    logic [NW-1:0] w_lim;
    logic [NW-1:0] w_num;
    logic [NW-1:0] w_idx;
    logic          w_in_free;
    logic          w_in_bad;
    logic          w_cfg_wr;

    logic [NW-1:0] r_used;
    logic [1:0]    r_status;
    logic [NW-1:0] r_granted;
    logic [4:0]    r_bit;
    logic [AW-1:0] r_waddr;
    logic [CW-1:0] r_addr;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    logic          r_m_valid;
    logic [bffa_pkg::M_TDATA_W-1:0] r_m_tdata;
    logic [1:0]    r_m_tuser;

    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [WW-1:0] w_wdata;
    logic [WW-1:0] w_rdata;

    logic [BW-1:0] w_base;
    logic [BW-1:0] w_limx;
    logic [BW-1:0] w_rem;
    logic          w_last;
    logic [WW-1:0] w_vmask;
    logic [WW-1:0] w_cand;
    logic          w_found;
    logic [4:0]    w_pos;
    logic          w_bit_set;
    logic          w_grant;
    logic [NW-1:0] w_free_cnt;

    // The managed count is capped at the size of the map.
    assign w_lim     = ({3'b000, r_limit} > NUM_X) ? NUM_X[NW-1:0] : r_limit;
    assign w_num     = i_s_tdata[NW-1:0];
    assign w_idx     = w_num - 14'd1;
    assign w_in_free = (i_s_tuser == bffa_pkg::CMD_FREE);
    assign w_in_bad  = (w_num == '0) || (w_num > w_lim);
    assign w_cfg_wr  = i_psel & i_penable & i_pwrite & (i_paddr[2] == bffa_pkg::REG_LIMIT);
    assign o_prdata  = (i_paddr[2] == bffa_pkg::REG_LIMIT) ? {18'd0, r_limit} : '0;

    // Scan of the word read last cycle: only bits below the limit count.
    assign w_base = BW'({r_pend_addr, 5'b00000});
    assign w_limx = BW'(w_lim);
    assign w_rem  = w_limx - w_base;
    assign w_last = (w_base + BW'(WW)) >= w_limx;

    always_comb begin
        for (int j = 0; j < WW; j++) begin
            w_vmask[j] = (BW'(j) < w_rem);
        end
    end

    assign w_cand  = ~w_rdata & w_vmask;
    assign w_found = |w_cand;

    always_comb begin
        w_pos = '0;
        for (int j = WW - 1; j >= 0; j--) begin
            if (w_cand[j]) w_pos = 5'(j);
        end
    end

    assign w_bit_set  = w_rdata[r_bit];
    assign w_grant    = i_cmd.scan & r_pend & w_found;
    assign w_free_cnt = (w_lim > r_used) ? (w_lim - r_used) : '0;

    // Bitmap RAM ports.
    assign w_re    = (i_cmd.accept & w_in_free & ~w_in_bad)
                   | (i_cmd.scan & (r_addr < CW'(WORDS)));
    assign w_raddr = i_cmd.accept ? AW'(w_idx[NW-1:5]) : r_addr[AW-1:0];
    assign w_we    = i_cmd.clear | (i_cmd.free_chk & w_bit_set) | w_grant;

    always_comb begin
        if (i_cmd.clear) begin
            w_waddr = r_addr[AW-1:0];
            w_wdata = '0;
        end else if (i_cmd.free_chk) begin
            w_waddr = r_waddr;
            w_wdata = w_rdata & ~(32'd1 << r_bit);
        end else begin
            w_waddr = r_pend_addr;
            w_wdata = w_rdata | (32'd1 << w_pos);
        end
    end

    bffa_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= bffa_pkg::LIMIT_RESET;
            r_used    <= '0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) r_limit <= i_pwdata[NW-1:0];
            if (i_cmd.accept) begin
                r_addr <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.clear | i_cmd.scan) begin
                r_addr <= r_addr + CW'(1);
            end
            if (i_cmd.scan) r_pend <= 1'b1;
            if (i_cmd.free_chk & w_bit_set & (r_used != '0)) begin
                r_used <= r_used - 14'd1;
            end else if (w_grant) begin
                r_used <= r_used + 14'd1;
            end
            if (i_cmd.load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_granted <= '0;
            r_bit     <= w_idx[4:0];
            r_waddr   <= AW'(w_idx[NW-1:5]);
            if (w_in_free) begin
                r_status <= w_in_bad ? bffa_pkg::ST_RANGE : bffa_pkg::ST_OK;
            end else begin
                r_status <= (w_lim == '0) ? bffa_pkg::ST_FULL : bffa_pkg::ST_OK;
            end
        end
        if (i_cmd.free_chk) begin
            r_status <= w_bit_set ? bffa_pkg::ST_OK : bffa_pkg::ST_NALLOC;
        end
        if (i_cmd.scan) begin
            r_pend_addr <= r_addr[AW-1:0];
            if (w_grant) begin
                r_granted <= NW'(w_base + BW'(w_pos) + BW'(1));
            end else if (r_pend & w_last) begin
                r_status <= bffa_pkg::ST_FULL;
            end
        end
        if (i_cmd.load) begin
            r_m_tdata <= {4'b0000, w_free_cnt, r_granted};
            r_m_tuser <= r_status;
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_addr == CW'(WORDS - 1));
        o_sts.in_free   = w_in_free;
        o_sts.in_bad    = w_in_bad;
        o_sts.lim_zero  = (w_lim == '0);
        o_sts.scan_done = r_pend & (w_found | w_last);
        o_sts.out_free  = ~r_m_valid | i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

// File: sv/bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap first-free allocator
// First-fit entry allocator over a one-bit-per-entry usage map.
// ----------------------------------------------------------------------------
// The block manages NUM_ENTRIES entries through a usage bitmap held in a RAM
// of 32-bit words, plus a count of the entries in use. Each input word is one
// command: tuser 0 allocates the lowest free entry below the configured limit
// and returns its one-based number, tuser 1 frees the one-based entry given in
// tdata. Every command yields exactly one result word with a status (ok, map
// full, number out of range, entry not allocated), the granted number (zero
// when nothing was allocated) and the number of entries still free. After
// reset the block clears the bitmap one word per cycle; input is held off
// until that pass ends, while register writes are taken at any time. A free
// passes through a check state that clears its bit in the bitmap before the
// result is loaded; a number out of range goes straight to the result. An
// allocation scans the bitmap one word per cycle through the single read
// port of the RAM, up to the word that holds the granted number or, when the
// map is full, the effective limit; with a zero limit it goes straight to the
// result. The next command can be accepted on the cycle after a result is
// loaded. Commands are handled one at a time, but a finished result sits in
// its own output register, so the next command is accepted while that result
// waits to be taken.
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_defines.svh"

module bitmap_first_free_allocator #(
    parameter int NUM_ENTRIES = 8192
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: [13:0] entry_number, [15:14] zero.
    input  logic [bffa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: [0] cmd.
    input  logic                           s_axis_tuser,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: [13:0] granted_number, [27:14] free_count, [31:28] zero.
    output logic [bffa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: [1:0] status.
    output logic [1:0]                     m_axis_tuser,
    // Register port: entries_in_use_limit at byte address 0.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bffa_pkg::APB_AW-1:0]    paddr,
    input  logic [bffa_pkg::APB_DW-1:0]    pwdata,
    output logic [bffa_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    bffa_pkg::t_ctl_cmd w_cmd;
    bffa_pkg::t_ctl_sts w_sts;
    logic               w_in_acc;
    logic               w_out_err;

    // Register accesses always complete in their access cycle.
    assign pready = 1'b1;

    // The controller walks each command through its steps.
    bffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_s_tready (s_axis_tready)
    );

    // The datapath owns the bitmap, counters, limit and result register.
    bffa_dp #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata)
    );

    // A command word is taken, and a result word carries a failure status.
    assign w_in_acc  = s_axis_tvalid & s_axis_tready;
    assign w_out_err = m_axis_tvalid & (m_axis_tuser != bffa_pkg::ST_OK);

    // Only one command is in flight: acceptance drops ready on the next cycle.
    `BFFA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    // A result is never loaded over one that has not been taken.
    `BFFA_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.load, !m_axis_tvalid || m_axis_tready)
    // Any status other than ok carries no granted number.
    `BFFA_ASSERT_IMP(a_grant_zero, i_clk, i_rst_n, w_out_err, m_axis_tdata[13:0] == 14'd0)

endmodule
